// ----- sv/ivalloc_pkg.sv -----
// ivalloc_pkg: shared types and codes of the interrupt vector allocator
// holds the request codes and the controller/datapath command and status structs
// no dependencies
package ivalloc_pkg;

  localparam logic OP_RESERVE  = 1'b0;
  localparam logic OP_ALLOCATE = 1'b1;

  localparam int unsigned TargetWidth = 8;
  localparam int unsigned LenWidth    = 9;
  localparam int unsigned BaseWidth   = 8;

  // controller -> datapath
  typedef struct packed {
    logic load_req;
    logic clr_step;
    logic rsv_write;
    logic set_fail;
    logic scan_start;
    logic scan_step;
    logic mark_step;
    logic out_load;
  } ivalloc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic is_alloc;
    logic len_zero;
    logic tgt_in_range;
    logic scan_found;
    logic scan_end;
    logic mark_last;
    logic out_free;
  } ivalloc_sts_t;

endpackage

// ----- sv/ivalloc_if.sv -----
// ivalloc_req_if / ivalloc_rsp_if: valid/ready channels of the allocator
// request carries op, target_vector, run_length; response carries success, base_vector
// no dependencies
interface ivalloc_req_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] target_vector;
  logic [8:0] run_length;

  modport source (output valid, output op, output target_vector, output run_length,
                  input ready);
  modport sink   (input valid, input op, input target_vector, input run_length,
                  output ready);
endinterface

interface ivalloc_rsp_if;
  logic       valid;
  logic       ready;
  logic       success;
  logic [7:0] base_vector;

  modport source (output valid, output success, output base_vector, input ready);
  modport sink   (input valid, input success, input base_vector, output ready);
endinterface

// ----- sv/ivalloc_ctrl.sv -----
// ivalloc_ctrl: sequencer of the allocator (clear pass, decode, scan, mark, respond)
// depends on ivalloc_pkg for the command and status structs
module ivalloc_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      req_valid_i,
  output logic                      req_ready_o,
  input  ivalloc_pkg::ivalloc_sts_t sts_i,
  output ivalloc_pkg::ivalloc_cmd_t cmd_o
);

  localparam logic [2:0] StClear  = 3'd0;
  localparam logic [2:0] StIdle   = 3'd1;
  localparam logic [2:0] StDecode = 3'd2;
  localparam logic [2:0] StScan   = 3'd3;
  localparam logic [2:0] StMark   = 3'd4;
  localparam logic [2:0] StResp   = 3'd5;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      StClear: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = StIdle;
      end
      StIdle: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = StDecode;
        end
      end
      StDecode: begin
        if (!sts_i.is_alloc) begin
          if (sts_i.tgt_in_range) cmd_o.rsv_write = 1'b1;
          else cmd_o.set_fail = 1'b1;
          state_d = StResp;
        end else if (sts_i.len_zero) begin
          cmd_o.set_fail = 1'b1;
          state_d        = StResp;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = StScan;
        end
      end
      StScan: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_found) begin
          state_d = StMark;
        end else if (sts_i.scan_end) begin
          cmd_o.set_fail = 1'b1;
          state_d        = StResp;
        end
      end
      StMark: begin
        cmd_o.mark_step = 1'b1;
        if (sts_i.mark_last) state_d = StResp;
      end
      StResp: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StClear;
      end
    endcase
  end

endmodule

// ----- sv/ivalloc_dp.sv -----
// ivalloc_dp: in-use memory, scan counters, run tracking and result registers
// depends on ivalloc_pkg for the command and status structs and request codes
module ivalloc_dp #(
  parameter int unsigned NUM_VECTORS = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ivalloc_pkg::ivalloc_cmd_t cmd_i,
  output ivalloc_pkg::ivalloc_sts_t sts_o,
  input  logic                      op_i,
  input  logic [7:0]                target_vector_i,
  input  logic [8:0]                run_length_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      success_o,
  output logic [7:0]                base_vector_o
);

  localparam int unsigned AW = (NUM_VECTORS > 1) ? $clog2(NUM_VECTORS) : 1;
  localparam logic [AW-1:0] LastIdx = AW'(NUM_VECTORS - 1);

  logic mem_q [NUM_VECTORS];

  logic          op_q;
  logic [7:0]    tgt_q;
  logic [8:0]    len_q;
  logic [AW-1:0] addr_q;
  logic          rd_more_q;
  logic          rd_vld_q;
  logic [AW-1:0] rd_idx_q;
  logic          rd_data_q;
  logic [8:0]    run_q;
  logic [AW-1:0] base_q;
  logic [8:0]    mark_cnt_q;
  logic          res_ok_q;
  logic [AW-1:0] res_base_q;
  logic          out_vld_q;
  logic          out_ok_q;
  logic [AW-1:0] out_base_q;

  logic [31:0]   tgt_ext;
  logic [AW-1:0] tgt_addr;
  logic          tgt_in_range;
  logic [8:0]    run_inc;
  logic [AW-1:0] cand_base;
  logic          found;
  logic          rd_last;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          rd_en;
  logic [31:0]   base_ext;

  assign tgt_ext      = 32'(tgt_q);
  assign tgt_addr     = tgt_ext[AW-1:0];
  assign tgt_in_range = tgt_ext < 32'(NUM_VECTORS);

  // a free mark extends the current run; the run starts at this index if empty
  assign run_inc   = run_q + 9'd1;
  assign cand_base = (run_q == '0) ? rd_idx_q : base_q;
  assign found     = rd_vld_q && !rd_data_q && (run_inc == len_q);
  assign rd_last   = rd_vld_q && (rd_idx_q == LastIdx);

  assign mem_we    = cmd_i.clr_step || cmd_i.rsv_write || cmd_i.mark_step;
  assign mem_waddr = cmd_i.rsv_write ? tgt_addr : addr_q;
  assign rd_en     = cmd_i.scan_step && rd_more_q && !found;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= !cmd_i.clr_step;
    if (rd_en) rd_data_q <= mem_q[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      op_q  <= op_i;
      tgt_q <= target_vector_i;
      len_q <= run_length_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q    <= '0;
      rd_more_q <= 1'b0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cmd_i.clr_step) begin
        addr_q <= (addr_q == LastIdx) ? '0 : addr_q + 1'b1;
      end else if (cmd_i.scan_start) begin
        addr_q    <= '0;
        rd_more_q <= 1'b1;
        rd_vld_q  <= 1'b0;
      end else if (cmd_i.scan_step) begin
        if (found) begin
          addr_q    <= cand_base;
          rd_more_q <= 1'b0;
          rd_vld_q  <= 1'b0;
        end else begin
          rd_vld_q <= rd_more_q;
          if (rd_more_q) begin
            if (addr_q == LastIdx) rd_more_q <= 1'b0;
            else addr_q <= addr_q + 1'b1;
          end
        end
      end else if (cmd_i.mark_step) begin
        addr_q <= addr_q + 1'b1;
      end

      if (cmd_i.out_load) out_vld_q <= 1'b1;
      else if (out_ready_i) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step && rd_vld_q) rd_idx_q <= addr_q;
    else if (rd_en) rd_idx_q <= addr_q;

    if (cmd_i.scan_start) begin
      run_q <= '0;
    end else if (cmd_i.scan_step && rd_vld_q) begin
      if (!rd_data_q) begin
        run_q  <= run_inc;
        base_q <= cand_base;
      end else begin
        run_q <= '0;
      end
    end

    if (cmd_i.scan_step && found) mark_cnt_q <= len_q;
    else if (cmd_i.mark_step) mark_cnt_q <= mark_cnt_q - 9'd1;

    if (cmd_i.rsv_write) begin
      res_ok_q   <= 1'b1;
      res_base_q <= tgt_addr;
    end else if (cmd_i.set_fail) begin
      res_ok_q   <= 1'b0;
      res_base_q <= '0;
    end else if (cmd_i.scan_step && found) begin
      res_ok_q   <= 1'b1;
      res_base_q <= cand_base;
    end

    if (cmd_i.out_load) begin
      out_ok_q   <= res_ok_q;
      out_base_q <= res_base_q;
    end
  end

  assign sts_o.clr_last     = addr_q == LastIdx;
  assign sts_o.is_alloc     = op_q == ivalloc_pkg::OP_ALLOCATE;
  assign sts_o.len_zero     = len_q == '0;
  assign sts_o.tgt_in_range = tgt_in_range;
  assign sts_o.scan_found   = found;
  assign sts_o.scan_end     = rd_last && !found;
  assign sts_o.mark_last    = mark_cnt_q == 9'd1;
  assign sts_o.out_free     = !out_vld_q || out_ready_i;

  assign base_ext      = 32'(out_base_q);
  assign out_valid_o   = out_vld_q;
  assign success_o     = out_ok_q;
  assign base_vector_o = base_ext[7:0];

endmodule

// ----- sv/interrupt_vector_allocator.sv -----
// interrupt_vector_allocator: top level of the vector allocator
// joins ivalloc_ctrl and ivalloc_dp; uses ivalloc_pkg and the ivalloc_if channels
//
// requests arrive on req_i (valid/ready): op reserve marks target_vector in use and
// always succeeds for a vector inside the table; op allocate finds the lowest run of
// run_length free vectors, marks it and returns its base, or fails with base 0.
// one response per request leaves on rsp_o (valid/ready) from an output register.
// one request is processed at a time; ready is high only while the block waits.
// a reserve or a zero-length allocate passes from decode straight to the response
// state; an allocate scans the marks and, on success, marks its run before it
// responds, or fails at the end of the table.
// the scan reads one mark per cycle from the single-port in-use memory, and marking
// writes one vector per cycle.
// after reset a clearing pass zeroes the whole in-use memory with ready low.
// a stalled rsp_o holds its response; the next request is taken once the finished
// response has moved into the output register.
module interrupt_vector_allocator #(
  parameter int unsigned NUM_VECTORS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ivalloc_req_if.sink   req_i,
  ivalloc_rsp_if.source rsp_o
);

  ivalloc_pkg::ivalloc_cmd_t cmd;
  ivalloc_pkg::ivalloc_sts_t sts;
  logic                      req_ready;

  ivalloc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ivalloc_dp #(
    .NUM_VECTORS (NUM_VECTORS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .op_i            (req_i.op),
    .target_vector_i (req_i.target_vector),
    .run_length_i    (req_i.run_length),
    .out_valid_o     (rsp_o.valid),
    .out_ready_i     (rsp_o.ready),
    .success_o       (rsp_o.success),
    .base_vector_o   (rsp_o.base_vector)
  );

  assign req_i.ready = req_ready;

endmodule
